// ----- hdl/crbf_pkg.sv -----
package crbf_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int MAX_READ    = 64;
    localparam int SIZE_W      = 7;
    localparam int CFG_W       = 13;
    localparam int DIV_STEP_W  = $clog2(CNT_W);

    typedef enum logic [1:0] {
        FN_WRITE,
        FN_READ,
        FN_CLOSE,
        FN_QUERY
    } func_t;

    typedef enum logic [2:0] {
        STAT_DATA,
        STAT_WR_OK,
        STAT_RETRY,
        STAT_EOS,
        STAT_FULL,
        STAT_QUERY
    } status_t;

    typedef enum logic {
        CFG_RECORD_SIZE,
        CFG_MAX_HELD
    } cfg_index_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_CFG,
        BK_DIV_WR,
        BK_SCAN,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        func_t             func;
        logic [7:0]        data;
        logic              last;
        logic [SIZE_W-1:0] want;
    } cmd_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       data;
        logic             last;
        logic [CNT_W-1:0] avail;
    } result_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size);
        return (size > SIZE_W'(MAX_READ)) ? SIZE_W'(MAX_READ) : size;
    endfunction

endpackage

// ----- hdl/crbf_front.sv -----
module crbf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,   // wr_byte [7:0], rd_size [14:8], zero [15]
    input  logic [1:0]      s_tuser,   // func [1:0]
    input  logic            s_tlast,
    output logic            cmd_valid,
    output crbf_pkg::cmd_t  cmd,
    input  logic            cmd_ready
);
    import crbf_pkg::*;

    cmd_t       q_reg [2];
    cmd_t       in_cmd;
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    always_comb begin
        in_cmd.func = func_t'(s_tuser);
        in_cmd.data = s_tdata[7:0];
        in_cmd.last = s_tlast;
        in_cmd.want = clamp_size(s_tdata[14:8]);
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

// ----- hdl/crbf_div.sv -----
module crbf_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [crbf_pkg::CNT_W-1:0]   dividend,
    input  logic [crbf_pkg::SIZE_W-1:0]  divisor,
    output logic                         done,
    output logic [crbf_pkg::CNT_W-1:0]   quotient
);
    import crbf_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]      quo_reg, quo_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [SIZE_W-1:0]     dsr_reg, dsr_next;
    logic [SIZE_W:0]       trial;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[CNT_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(CNT_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = SIZE_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[CNT_W-2:0], 1'b1};
            end else begin
                rem_next = trial[SIZE_W-1:0];
                quo_next = {quo_reg[CNT_W-2:0], 1'b0};
            end
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ----- hdl/crbf_back.sv -----
module crbf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    input  crbf_pkg::cmd_t              cmd,
    output logic                        cmd_ready,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [crbf_pkg::CFG_W-1:0]  cfg_wdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // rd_byte [7:0], available [20:8], zero [23:21]
    output logic [2:0]                  m_tuser,   // status [2:0]
    output logic                        m_tlast
);
    import crbf_pkg::*;

    logic [8:0] mem [STORE_DEPTH];

    bk_state_t         state_reg, state_next;
    logic [ADDR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0]  bytes_reg, bytes_next;
    logic [CNT_W-1:0]  chunks_reg, chunks_next;
    logic [CNT_W-1:0]  records_reg, records_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic              closed_reg, closed_next;
    logic              drop_reg, drop_next;
    logic              inchunk_reg, inchunk_next;
    logic [SIZE_W-1:0] rsize_reg, rsize_next;
    logic [CFG_W-1:0]  maxh_reg, maxh_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0] iss_reg, iss_next;
    logic [SIZE_W-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]  avail_reg, avail_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              rd_scan_reg, rd_scan_next;
    logic              rd_last_reg, rd_last_next;
    logic [8:0]        rd_data_reg;
    result_t           ofifo_reg [2];
    logic              owp_reg, owp_next, orp_reg, orp_next;
    logic [1:0]        ocnt_reg, ocnt_next;

    logic [SIZE_W-1:0] rs, cfg_rs, div_divisor;
    logic [CNT_W-1:0]  held, div_dividend, div_quot;
    logic              div_start, div_done;
    logic              cmd_take, pop, ret_push, scan_hit, scan_done;
    logic              wr_eos, wr_retry, wr_full, wr_store, wr_commit_div;
    logic              rd_eos, rd_scan_go, rd_rec_go;
    logic              cfg_rs_wr, cfg_div;
    logic [2:0]        room_cnt;
    logic              em_issue, sc_issue;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              push;
    result_t           push_res, out_res;

    crbf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        rs        = clamp_size(rsize_reg);
        held      = (rs == '0) ? chunks_reg : records_reg;
        pop       = m_tvalid && m_tready;
        cmd_take  = (state_reg == BK_IDLE) && cmd_valid && (ocnt_reg != 2'd2);
        ret_push  = (state_reg == BK_EMIT) && rd_vld_reg && !rd_scan_reg;
        scan_hit  = (state_reg == BK_SCAN) && rd_vld_reg && rd_scan_reg;
        scan_done = scan_hit && (rd_data_reg[8] || (seen_reg + 1'b1 == cnt_reg));

        wr_eos   = !inchunk_reg && closed_reg && (held == '0);
        wr_retry = !inchunk_reg && (maxh_reg != '0) && (held > maxh_reg);
        wr_full  = ({1'b0, bytes_reg} + {1'b0, pend_reg}) >= (CNT_W + 1)'(STORE_DEPTH);
        wr_store = (cmd.func == FN_WRITE) && !drop_reg && !wr_eos && !wr_retry && !wr_full;
        wr_commit_div = cmd_take && wr_store && cmd.last && (rs != '0);

        rd_eos     = closed_reg && (held == '0);
        rd_scan_go = cmd_take && (cmd.func == FN_READ) && !rd_eos && (rs == '0)
                     && (cmd.want != '0) && (chunks_reg != '0) && (bytes_reg != '0);
        rd_rec_go  = cmd_take && (cmd.func == FN_READ) && !rd_eos && (rs != '0)
                     && (records_reg != '0);

        cfg_rs    = clamp_size(cfg_wdata[SIZE_W-1:0]);
        cfg_rs_wr = cfg_we && (cfg_index == CFG_RECORD_SIZE);
        cfg_div   = cfg_rs_wr && (cfg_rs != '0);

        room_cnt = {1'b0, ocnt_reg} + {2'b0, ret_push} - {2'b0, pop};
        em_issue = (state_reg == BK_EMIT) && (iss_reg != cnt_reg) && (room_cnt < 3'd2);
        sc_issue = (state_reg == BK_SCAN) && (iss_reg != cnt_reg) && !scan_done;
    end

    assign cmd_ready = cmd_take;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                priority if (cfg_div) begin
                    state_next = BK_DIV_CFG;
                end else if (wr_commit_div) begin
                    state_next = BK_DIV_WR;
                end else if (rd_scan_go) begin
                    state_next = BK_SCAN;
                end else if (rd_rec_go) begin
                    state_next = BK_EMIT;
                end
            end
            BK_DIV_CFG: begin
                priority if (cfg_div) begin
                    state_next = BK_DIV_CFG;
                end else if (cfg_rs_wr || div_done) begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIV_WR: begin
                if (div_done) begin
                    state_next = BK_IDLE;
                end
            end
            BK_SCAN: begin
                if (scan_done) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (iss_reg == cnt_reg) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        bytes_next   = bytes_reg;
        chunks_next  = chunks_reg;
        records_next = records_reg;
        pend_next    = pend_reg;
        closed_next  = closed_reg;
        drop_next    = drop_reg;
        inchunk_next = inchunk_reg;
        rsize_next   = rsize_reg;
        maxh_next    = maxh_reg;
        cnt_next     = cnt_reg;
        iss_next     = iss_reg;
        seen_next    = seen_reg;
        avail_next   = avail_reg;
        rd_scan_next = rd_scan_reg;
        rd_last_next = rd_last_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = rp_reg;
        push         = 1'b0;
        push_res     = '{status: STAT_QUERY, data: 8'd0, last: 1'b1, avail: held};
        div_start    = 1'b0;
        div_dividend = bytes_reg;
        div_divisor  = rs;

        if (cfg_we) begin
            if (cfg_index == CFG_RECORD_SIZE) begin
                rsize_next = cfg_wdata[SIZE_W-1:0];
            end else begin
                maxh_next = cfg_wdata;
            end
        end
        if (cfg_div) begin
            div_start   = 1'b1;
            div_divisor = cfg_rs;
        end

        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_take) begin
                    unique case (cmd.func)
                        FN_WRITE: begin
                            priority if (drop_reg) begin
                                drop_next = !cmd.last;
                            end else if (wr_eos || wr_retry) begin
                                drop_next       = !cmd.last;
                                push            = 1'b1;
                                push_res.status = wr_eos ? STAT_EOS : STAT_RETRY;
                            end else if (wr_full) begin
                                wp_next         = rp_reg + bytes_reg[ADDR_W-1:0];
                                inchunk_next    = 1'b0;
                                pend_next       = '0;
                                drop_next       = !cmd.last;
                                push            = 1'b1;
                                push_res.status = STAT_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                wp_next = wp_reg + 1'b1;
                                push_res.status = STAT_WR_OK;
                                if (cmd.last) begin
                                    bytes_next   = bytes_reg + pend_reg + 1'b1;
                                    chunks_next  = chunks_reg + 1'b1;
                                    inchunk_next = 1'b0;
                                    pend_next    = '0;
                                    if (rs != '0) begin
                                        div_start    = 1'b1;
                                        div_dividend = bytes_next;
                                    end else begin
                                        push           = 1'b1;
                                        push_res.avail = chunks_next;
                                    end
                                end else begin
                                    inchunk_next = 1'b1;
                                    pend_next    = pend_reg + 1'b1;
                                    push         = 1'b1;
                                end
                            end
                        end
                        FN_READ: begin
                            priority if (rd_scan_go) begin
                                cnt_next  = cmd.want;
                                iss_next  = '0;
                                seen_next = '0;
                            end else if (rd_rec_go) begin
                                cnt_next     = rs;
                                iss_next     = '0;
                                records_next = records_reg - 1'b1;
                                avail_next   = records_reg - 1'b1;
                            end else begin
                                push            = 1'b1;
                                push_res.status = rd_eos ? STAT_EOS : STAT_RETRY;
                            end
                        end
                        FN_CLOSE: begin
                            closed_next = 1'b1;
                            push        = 1'b1;
                        end
                        FN_QUERY: begin
                            push = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            BK_DIV_CFG: begin
                if (div_done) begin
                    records_next = div_quot;
                end
            end
            BK_DIV_WR: begin
                if (div_done) begin
                    records_next = div_quot;
                    push         = 1'b1;
                    push_res     = '{status: STAT_WR_OK, data: 8'd0, last: 1'b1,
                                     avail: div_quot};
                end
            end
            BK_SCAN: begin
                if (sc_issue) begin
                    mem_re       = 1'b1;
                    mem_raddr    = rp_reg + ADDR_W'(iss_reg);
                    rd_scan_next = 1'b1;
                    iss_next     = iss_reg + 1'b1;
                end
                if (scan_hit) begin
                    if (scan_done) begin
                        cnt_next   = seen_reg + 1'b1;
                        iss_next   = '0;
                        avail_next = chunks_reg - CNT_W'(rd_data_reg[8]);
                    end else begin
                        seen_next = seen_reg + 1'b1;
                    end
                end
            end
            BK_EMIT: begin
                if (ret_push) begin
                    push     = 1'b1;
                    push_res = '{status: STAT_DATA, data: rd_data_reg[7:0],
                                 last: rd_last_reg, avail: avail_reg};
                    if (rd_data_reg[8] && (chunks_reg != '0)) begin
                        chunks_next = chunks_reg - 1'b1;
                    end
                end
                if (em_issue) begin
                    mem_re       = 1'b1;
                    rp_next      = rp_reg + 1'b1;
                    iss_next     = iss_reg + 1'b1;
                    rd_last_next = (iss_reg == cnt_reg - 1'b1);
                    rd_scan_next = 1'b0;
                    if (bytes_reg != '0) begin
                        bytes_next = bytes_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase

        rd_vld_next = mem_re;
        owp_next    = push ? !owp_reg : owp_reg;
        orp_next    = pop ? !orp_reg : orp_reg;
        ocnt_next   = ocnt_reg + {1'b0, push} - {1'b0, pop};
    end

    assign out_res  = ofifo_reg[orp_reg];
    assign m_tvalid = (ocnt_reg != 2'd0);
    assign m_tdata  = {3'b000, out_res.avail, out_res.data};
    assign m_tuser  = out_res.status;
    assign m_tlast  = out_res.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            bytes_reg   <= '0;
            chunks_reg  <= '0;
            records_reg <= '0;
            pend_reg    <= '0;
            closed_reg  <= 1'b0;
            drop_reg    <= 1'b0;
            inchunk_reg <= 1'b0;
            rsize_reg   <= '0;
            maxh_reg    <= '0;
            cnt_reg     <= '0;
            iss_reg     <= '0;
            seen_reg    <= '0;
            avail_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_scan_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            owp_reg     <= 1'b0;
            orp_reg     <= 1'b0;
            ocnt_reg    <= 2'd0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            bytes_reg   <= bytes_next;
            chunks_reg  <= chunks_next;
            records_reg <= records_next;
            pend_reg    <= pend_next;
            closed_reg  <= closed_next;
            drop_reg    <= drop_next;
            inchunk_reg <= inchunk_next;
            rsize_reg   <= rsize_next;
            maxh_reg    <= maxh_next;
            cnt_reg     <= cnt_next;
            iss_reg     <= iss_next;
            seen_reg    <= seen_next;
            avail_reg   <= avail_next;
            rd_vld_reg  <= rd_vld_next;
            rd_scan_reg <= rd_scan_next;
            rd_last_reg <= rd_last_next;
            owp_reg     <= owp_next;
            orp_reg     <= orp_next;
            ocnt_reg    <= ocnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= {cmd.last, cmd.data};
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ofifo_reg[owp_reg] <= push_res;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_IDLE) |-> !rd_vld_reg)
        else $error("Store read outstanding while the engine is idle.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (ocnt_reg != 2'd2))
        else $error("Result queue overflow.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, bytes_reg} + {1'b0, pend_reg}) <= (CNT_W + 1)'(STORE_DEPTH))
        else $error("Committed and open bytes exceed the store.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (chunks_reg == '0) |-> (bytes_reg == '0))
        else $error("Committed bytes held without a committed chunk.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_EMIT) |-> (iss_reg <= cnt_reg))
        else $error("Read issued more bytes than requested.");

endmodule

// ----- hdl/chunked_record_byte_fifo.sv -----
// Byte FIFO that keeps chunk boundaries and can hand data back as fixed-size records.
// Requests enter on the s_ channel: func in s_tuser selects write byte, read, close or
// status query; s_tlast marks the final byte of a written chunk. Every request that
// gives results ends its results with m_tlast high; a dropped byte gives none.
// Results leave on the m_ channel with the status in m_tuser and byte plus count in m_tdata.
// The user must write record_size and max_held through cfg_we, cfg_index and cfg_wdata
// only while idle; the block does not enforce this. After a write, close or query the
// engine can take the next request while the result queue has room, but the final byte
// of a chunk in record mode and a nonzero record_size write wait for a serial divide of
// the committed byte count. A chunk-mode read of n bytes scans the head chunk for its end
// through the store read port, then streams up to n bytes, to the chunk end; a record-mode
// read streams its record_size bytes right away. Both stream one byte per cycle while the
// result queue has room. After reset the store is empty, the stream is open and both
// registers are zero; no clearing pass is needed. When the receiver stalls, a two-entry
// result queue fills, the engine pauses, and a two-entry request queue then drops s_tready.
module chunked_record_byte_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // wr_byte [7:0], rd_size [14:8], zero [15]
    input  logic [1:0]                  s_tuser,   // func [1:0]
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // rd_byte [7:0], available [20:8], zero [23:21]
    output logic [2:0]                  m_tuser,   // status [2:0]
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [crbf_pkg::CFG_W-1:0]  cfg_wdata
);
    import crbf_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    crbf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    crbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- tb/chunked_record_byte_fifo_test.sv -----
`timescale 1ns / 1ps

module chunked_record_byte_fifo_test;
    import crbf_pkg::*;

    class fifo_scoreboard;
        logic [8:0]  mem [STORE_DEPTH];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int unsigned committed;
        int unsigned chunk_count;
        int unsigned rec_bytes;
        int unsigned cap;
        bit          is_closed;
        bit          skipping;
        bit          open_chunk;
        result_t     staged [$];
        result_t     results_due [$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            wr_ptr       = 0;
            rd_ptr       = 0;
            committed    = 0;
            chunk_count  = 0;
            rec_bytes    = 0;
            cap          = 0;
            is_closed    = 1'b0;
            skipping     = 1'b0;
            open_chunk   = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_config(cfg_index_t idx, logic [CFG_W-1:0] val);
            if (idx == CFG_RECORD_SIZE) begin
                rec_bytes = val[SIZE_W-1:0];
            end else begin
                cap = val;
            end
        endfunction

        function int unsigned record_len();
            return (rec_bytes > MAX_READ) ? MAX_READ : rec_bytes;
        endfunction

        function int unsigned held_units();
            int unsigned rl;
            rl = record_len();
            return (rl == 0) ? chunk_count : committed / rl;
        endfunction

        function int unsigned tail_index();
            return (rd_ptr + committed) % STORE_DEPTH;
        endfunction

        function int unsigned open_len();
            int unsigned p;
            if (!open_chunk) begin
                return 0;
            end
            p = (wr_ptr + STORE_DEPTH - tail_index()) % STORE_DEPTH;
            return (p == 0) ? STORE_DEPTH : p;
        endfunction

        function void put(status_t s, logic [7:0] b);
            result_t r;
            r.status = s;
            r.data   = b;
            r.last   = 1'b0;
            r.avail  = '0;
            staged.push_back(r);
        endfunction

        function logic [8:0] pop_cell();
            logic [8:0] v;
            v = mem[ADDR_W'(rd_ptr)];
            rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
            if (committed > 0) begin
                committed--;
            end
            if (v[8] && chunk_count > 0) begin
                chunk_count--;
            end
            return v;
        endfunction

        function void take_byte(logic [7:0] b, logic l);
            int unsigned c;
            int unsigned p;
            if (skipping) begin
                if (l) begin
                    skipping = 1'b0;
                end
                return;
            end
            if (!open_chunk) begin
                c = held_units();
                if (is_closed && c == 0) begin
                    skipping = !l;
                    put(STAT_EOS, 8'h00);
                    return;
                end
                if (cap != 0 && c > cap) begin
                    skipping = !l;
                    put(STAT_RETRY, 8'h00);
                    return;
                end
            end
            p = open_len();
            if (committed + p >= STORE_DEPTH) begin
                wr_ptr     = tail_index();
                open_chunk = 1'b0;
                skipping   = !l;
                put(STAT_FULL, 8'h00);
                return;
            end
            mem[ADDR_W'(wr_ptr)] = {l, b};
            wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
            if (l) begin
                committed += p + 1;
                chunk_count++;
                open_chunk = 1'b0;
            end else begin
                open_chunk = 1'b1;
            end
            put(STAT_WR_OK, 8'h00);
        endfunction

        function void serve_read(logic [SIZE_W-1:0] want);
            int unsigned rl;
            int unsigned n;
            int unsigned k;
            logic [8:0]  v;
            bit          at_end;
            rl = record_len();
            at_end = 1'b0;
            if (is_closed && held_units() == 0) begin
                put(STAT_EOS, 8'h00);
                return;
            end
            if (rl == 0) begin
                n = (want > MAX_READ) ? MAX_READ : want;
                if (n == 0 || chunk_count == 0 || committed == 0) begin
                    put(STAT_RETRY, 8'h00);
                    return;
                end
                for (k = 0; k < n && committed > 0 && !at_end; k++) begin
                    v = pop_cell();
                    put(STAT_DATA, v[7:0]);
                    at_end = v[8];
                end
                return;
            end
            if (committed / rl == 0) begin
                put(STAT_RETRY, 8'h00);
                return;
            end
            for (k = 0; k < rl; k++) begin
                v = pop_cell();
                put(STAT_DATA, v[7:0]);
            end
        endfunction

        function void note_request(func_t f, logic [7:0] b, logic l, logic [SIZE_W-1:0] want);
            int unsigned c;
            staged.delete();
            case (f)
                FN_WRITE: begin
                    take_byte(b, l);
                end
                FN_READ: begin
                    serve_read(want);
                end
                FN_CLOSE: begin
                    is_closed = 1'b1;
                    put(STAT_QUERY, 8'h00);
                end
                default: begin
                    put(STAT_QUERY, 8'h00);
                end
            endcase
            c = held_units();
            foreach (staged[k]) begin
                staged[k].last  = (k == staged.size() - 1);
                staged[k].avail = CNT_W'(c);
                results_due.push_back(staged[k]);
            end
        endfunction

        function void check_result(result_t got);
            result_t due;
            results_seen++;
            if (results_due.size() == 0) begin
                $error("result with nothing awaited: status %0d rd_byte %0h",
                       got.status, got.data);
                mismatches++;
                return;
            end
            due = results_due.pop_front();
            if (got.status !== due.status) begin
                $error("status expected %0d actual %0d", due.status, got.status);
                mismatches++;
            end
            if (got.data !== due.data) begin
                $error("rd_byte expected %0h actual %0h", due.data, got.data);
                mismatches++;
            end
            if (got.last !== due.last) begin
                $error("last expected %0d actual %0d", due.last, got.last);
                mismatches++;
            end
            if (got.avail !== due.avail) begin
                $error("available expected %0d actual %0d", due.avail, got.avail);
                mismatches++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 40;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata   = '0;   // wr_byte [7:0], rd_size [14:8], zero [15]
    logic [1:0]       s_tuser   = '0;   // func [1:0]
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [23:0]      m_tdata;          // rd_byte [7:0], available [20:8], zero [23:21]
    logic [2:0]       m_tuser;          // status [2:0]
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    fifo_scoreboard sb = new();

    int unsigned sender_max_gap     = 0;
    int unsigned receiver_max_stall = 0;
    int unsigned hold_off           = 0;
    int unsigned requests_sent      = 0;
    int unsigned idle_cycles        = 0;

    chunked_record_byte_fifo u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        result_t     got;
        wait (aresetn);
        forever begin
            stall = (hold_off != 0) ? hold_off : $urandom_range(0, receiver_max_stall);
            hold_off = 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.status = status_t'(m_tuser);
            got.data   = m_tdata[7:0];
            got.last   = m_tlast;
            got.avail  = m_tdata[20:8];
            sb.check_result(got);
        end
    end

    task automatic send_request(func_t f, logic [7:0] b, logic l, logic [SIZE_W-1:0] want);
        int unsigned gap;
        gap = $urandom_range(0, sender_max_gap);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {1'b0, want, b};
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(f, b, l, want);
        requests_sent++;
    endtask

    task automatic write_byte(logic [7:0] b, logic l);
        send_request(FN_WRITE, b, l, SIZE_W'($urandom_range(0, 127)));
    endtask

    task automatic read_bytes(logic [SIZE_W-1:0] want);
        send_request(FN_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), want);
    endtask

    task automatic query_state();
        send_request(FN_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     SIZE_W'($urandom_range(0, 127)));
    endtask

    task automatic write_chunk(int unsigned len);
        int unsigned k;
        for (k = 0; k < len; k++) begin
            write_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_config(idx, val);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(int unsigned n_items);
        int unsigned chunk_left;
        int unsigned pick;
        chunk_left = 0;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (chunk_left != 0 && pick < 75) begin
                write_byte(8'($urandom_range(0, 255)), chunk_left == 1);
                chunk_left--;
            end else if (chunk_left == 0 && pick < 45) begin
                chunk_left = (pick < 6) ? $urandom_range(13, 70) : $urandom_range(1, 12);
                write_byte(8'($urandom_range(0, 255)), chunk_left == 1);
                chunk_left--;
            end else if (pick < 92) begin
                read_bytes(($urandom_range(0, 4) == 0) ? SIZE_W'($urandom_range(0, 127))
                                                       : SIZE_W'($urandom_range(1, 64)));
            end else begin
                query_state();
            end
        end
        while (chunk_left != 0) begin
            write_byte(8'($urandom_range(0, 255)), chunk_left == 1);
            chunk_left--;
        end
    endtask

    initial begin : stimulus
        int unsigned rec_list [8] = '{0, 3, 0, 64, 1, 127, 7, 0};
        int unsigned cap_list [8] = '{0, 2, 1, 0, 4096, 3, 1, 8};
        int unsigned ph;
        wait (aresetn);
        sender_max_gap     = 3;
        receiver_max_stall = 3;

        query_state();
        read_bytes(7'd64);
        write_byte(8'h00, 1'b0);
        write_byte(8'hFF, 1'b1);
        write_byte(8'hA5, 1'b1);
        read_bytes(7'd0);
        read_bytes(7'd1);
        read_bytes(7'd100);
        read_bytes(7'd64);
        write_byte(8'h5A, 1'b0);
        write_byte(8'h3C, 1'b0);
        write_byte(8'hC3, 1'b1);
        read_bytes(7'd2);
        read_bytes(7'd127);

        quiesce();
        write_reg(CFG_MAX_HELD, 13'd1);
        write_byte(8'h11, 1'b1);
        write_byte(8'h22, 1'b1);
        write_byte(8'h33, 1'b0);
        write_byte(8'h44, 1'b0);
        write_byte(8'h55, 1'b1);

        quiesce();
        write_reg(CFG_RECORD_SIZE, 13'd3);
        write_reg(CFG_MAX_HELD, 13'd0);
        write_byte(8'h66, 1'b0);
        write_byte(8'h77, 1'b0);
        write_byte(8'h88, 1'b1);
        write_byte(8'h99, 1'b1);
        read_bytes(7'd0);
        read_bytes(7'd0);
        read_bytes(7'd0);

        for (ph = 0; ph < 8; ph++) begin
            quiesce();
            write_reg(CFG_RECORD_SIZE, CFG_W'(rec_list[ph]));
            write_reg(CFG_MAX_HELD, CFG_W'(cap_list[ph]));
            sender_max_gap     = (ph % 3 == 0) ? 0 : 5;
            receiver_max_stall = (ph % 4 == 1) ? 0 : 5;
            if (ph == 2) begin
                sender_max_gap = 0;
                hold_off       = LONG_HOLD;
            end
            random_phase(40);
        end

        quiesce();
        write_reg(CFG_RECORD_SIZE, 13'd0);
        write_reg(CFG_MAX_HELD, 13'd0);
        sender_max_gap     = 2;
        receiver_max_stall = 2;
        while (sb.committed != 0) read_bytes(7'd64);

        quiesce();
        write_reg(CFG_RECORD_SIZE, 13'd3);
        write_chunk(5);
        send_request(FN_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     SIZE_W'($urandom_range(0, 127)));
        write_chunk(1);
        read_bytes(7'd0);
        read_bytes(7'd0);
        read_bytes(7'd0);
        write_chunk(2);
        query_state();

        quiesce();
        $display("Checked %0d requests and %0d results across chunk and record modes,",
                 requests_sent, sb.results_seen);
        $display("with held-count limits, a long output stall, a drain and a close.");
        if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
